@@ src/pva_pkg.sv @@
// Shared constants and types for the polyphonic voice allocator.
package pva_pkg;

    localparam int VOICES  = 8;
    localparam int VOICE_W = 3;
    localparam int CNT_W   = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int AGE_W   = 32;
    localparam int SENS_W  = 5;

    localparam logic [NOTE_W-1:0] NOTE_LOW   = 7'd24;
    localparam logic [NOTE_W-1:0] NOTE_HIGH  = 7'd107;
    localparam logic [6:0]        PEDAL_HALF = 7'd64;
    localparam logic [SENS_W-1:0] SENS_MAX   = 5'd16;

    typedef enum logic [2:0] {
        OP_NOTE_ON       = 3'd0,
        OP_NOTE_OFF      = 3'd1,
        OP_PEDAL         = 3'd2,
        OP_VOICE_DONE    = 3'd3,
        OP_ALL_NOTES_OFF = 3'd4,
        OP_ALL_SOUND_OFF = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_RETRIG  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_KILL    = 2'd3
    } act_t;

    typedef enum logic {
        CFG_VOICE_COUNT = 1'b0,
        CFG_VEL_SENS    = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FLUSH,
        S_FINAL
    } state_t;

endpackage

@@ src/poly_voice_allocator_unit.sv @@
// Polyphonic voice allocator: note events in, per-voice actions out.
//
//  channel   dir  handshake              payload
//  -------   ---  ---------------------  ------------------------------------------
//  s_*       in   s_tvalid / s_tready    s_tdata: opcode, note, velocity, pedal, id
//  m_*       out  m_tvalid / m_tready    m_tdata: action, voice, note, vel, age
//                                        m_tlast: final result of the input item
//  cfg_*     in   cfg_we                 cfg_index, cfg_data
//
// Note on/off, pedal release and all-off events scan the voice memory voice by
// voice (read, then evaluate); a note on stops at the first free or matching
// voice, and m_tready low can stall a release scan or the final result. Other events need no scan.
// Reset clears all voice flags, the age counter and hold; the voice memory
// needs no clearing since the data of voices not playing is never used.
module poly_voice_allocator_unit
    import pva_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // opcode, note, velocity, pedal_value, voice_id
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,   // action, voice, note_out, scaled_velocity, age_stamp
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [SENS_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic [SENS_W-1:0]  sens_reg;
    logic [VOICES-1:0]  playing_reg;
    logic [VOICES-1:0]  released_reg;
    logic [AGE_W-1:0]   next_age_reg;
    logic               hold_reg;

    op_t                op_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [CNT_W-1:0]   lim_reg;
    logic [VOICE_W-1:0] idx_reg;

    logic [NOTE_W+AGE_W-1:0] voice_mem [VOICES];
    logic [NOTE_W+AGE_W-1:0] rd_data_reg;

    logic               rel_found_reg, old_found_reg;
    logic [VOICE_W-1:0] rel_pick_reg, old_pick_reg;
    logic [AGE_W-1:0]   rel_age_reg, old_age_reg;

    act_t               act_reg;
    logic [VOICE_W-1:0] pick_reg;

    logic               pend_valid_reg;
    act_t               pend_act_reg;
    logic [VOICE_W-1:0] pend_voice_reg;
    logic [NOTE_W-1:0]  pend_note_reg;

    logic               out_valid_reg;
    act_t               out_act_reg;
    logic [VOICE_W-1:0] out_voice_reg;
    logic [NOTE_W-1:0]  out_note_reg;
    logic [VEL_W-1:0]   out_vel_reg;
    logic [AGE_W-1:0]   out_age_reg;
    logic               out_last_reg;

    // input fields
    op_t                s_op;
    logic [NOTE_W-1:0]  s_note;
    logic [VEL_W-1:0]   s_vel;
    logic [6:0]         s_pedal;
    logic [VOICE_W-1:0] s_vid;

    logic               in_acc, out_free;
    logic [SENS_W-1:0]  sens_inv;
    logic [6:0]         floor_v;
    logic [7:0]         span;
    logic [14:0]        prod;
    logic [7:0]         scaled_sum;
    logic               start_scan;
    logic [CNT_W-1:0]   start_lim;

    logic [NOTE_W-1:0]  rd_note;
    logic [AGE_W-1:0]   rd_age;
    logic               cur_play, cur_rel, note_match, scan_end;
    logic               on_done_now, rel_hit, eval_stall;
    logic               rel_upd, old_upd;
    logic [VOICE_W-1:0] steal_pick;

    logic               mem_rd, hit_take, pend_push, flush_push, final_push, flush_done;

    assign s_op    = op_t'(s_tdata[2:0]);
    assign s_note  = s_tdata[9:3];
    assign s_vel   = s_tdata[16:10];
    assign s_pedal = s_tdata[23:17];
    assign s_vid   = s_tdata[26:24];

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // velocity: floor + vel * (128 - floor) / 128
    assign sens_inv   = SENS_MAX - sens_reg;
    assign floor_v    = {sens_inv[3:0], 3'b000};
    assign span       = 8'd128 - {1'b0, floor_v};
    assign prod       = {8'b0, s_vel} * {7'b0, span};
    assign scaled_sum = {1'b0, floor_v} + prod[14:7];

    always_comb
    begin
        start_scan = 1'b0;
        start_lim  = CNT_W'(VOICES);
        case (s_op)
            OP_NOTE_ON:
            begin
                start_scan = (s_note >= NOTE_LOW) && (s_note <= NOTE_HIGH);
                start_lim  = cnt_reg;
            end
            OP_NOTE_OFF:
            begin
                start_scan = !hold_reg;
                start_lim  = cnt_reg;
            end
            OP_PEDAL:         start_scan = s_pedal < PEDAL_HALF;
            OP_ALL_NOTES_OFF: start_scan = 1'b1;
            OP_ALL_SOUND_OFF: start_scan = 1'b1;
            default:          start_scan = 1'b0;
        endcase
    end

    assign rd_note     = rd_data_reg[NOTE_W+AGE_W-1:AGE_W];
    assign rd_age      = rd_data_reg[AGE_W-1:0];
    assign cur_play    = playing_reg[idx_reg];
    assign cur_rel     = released_reg[idx_reg];
    assign note_match  = rd_note == note_reg;
    assign scan_end    = {1'b0, idx_reg} == (lim_reg - CNT_W'(1));
    assign on_done_now = !cur_play || note_match;

    assign rel_upd    = cur_rel && (!rel_found_reg || (rd_age < rel_age_reg));
    assign old_upd    = !old_found_reg || (rd_age < old_age_reg);
    assign steal_pick = rel_upd       ? idx_reg      :
                        rel_found_reg ? rel_pick_reg :
                        old_upd       ? idx_reg      : old_pick_reg;

    always_comb
    begin
        case (op_reg)
            OP_NOTE_OFF:      rel_hit = cur_play && !cur_rel && note_match;
            OP_PEDAL:         rel_hit = cur_play && !cur_rel;
            OP_ALL_NOTES_OFF: rel_hit = cur_play && !cur_rel;
            OP_ALL_SOUND_OFF: rel_hit = cur_play;
            default:          rel_hit = 1'b0;
        endcase
    end

    assign eval_stall = rel_hit && pend_valid_reg && !out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && start_scan)
                    state_next = S_READ;
            S_READ:
                state_next = S_EVAL;
            S_EVAL:
                if (op_reg == OP_NOTE_ON)
                begin
                    if (on_done_now || scan_end)
                        state_next = S_FINAL;
                    else
                        state_next = S_READ;
                end
                else if (!eval_stall)
                begin
                    state_next = scan_end ? S_FLUSH : S_READ;
                end
            S_FLUSH:
                if (!pend_valid_reg || out_free)
                    state_next = S_IDLE;
            S_FINAL:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = state_reg == S_IDLE;
        mem_rd     = state_reg == S_READ;
        hit_take   = (state_reg == S_EVAL) && (op_reg != OP_NOTE_ON) && rel_hit && !eval_stall;
        pend_push  = hit_take && pend_valid_reg;
        flush_done = (state_reg == S_FLUSH) && (!pend_valid_reg || out_free);
        flush_push = flush_done && pend_valid_reg;
        final_push = (state_reg == S_FINAL) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration, voice flags, age counter, hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CNT_W'(VOICES);
            sens_reg      <= SENS_MAX;
            playing_reg   <= '0;
            released_reg  <= '0;
            next_age_reg  <= '0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_VOICE_COUNT:
                        if (cfg_data[3:0] == 4'd0)
                            cnt_reg <= CNT_W'(1);
                        else if (cfg_data[3:0] > CNT_W'(VOICES))
                            cnt_reg <= CNT_W'(VOICES);
                        else
                            cnt_reg <= cfg_data[3:0];
                    CFG_VEL_SENS:
                        if (cfg_data == '0)
                            sens_reg <= SENS_W'(1);
                        else if (cfg_data > SENS_MAX)
                            sens_reg <= SENS_MAX;
                        else
                            sens_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                case (s_op)
                    OP_PEDAL:
                        hold_reg <= s_pedal >= PEDAL_HALF;
                    OP_VOICE_DONE:
                        if ({1'b0, s_vid} < CNT_W'(VOICES))
                        begin
                            playing_reg[s_vid]  <= 1'b0;
                            released_reg[s_vid] <= 1'b0;
                        end
                    default: ;
                endcase
            end
            if (hit_take)
            begin
                if (op_reg == OP_ALL_SOUND_OFF)
                begin
                    playing_reg[idx_reg]  <= 1'b0;
                    released_reg[idx_reg] <= 1'b0;
                end
                else
                begin
                    released_reg[idx_reg] <= 1'b1;
                end
            end
            if (final_push)
            begin
                playing_reg[pick_reg]  <= 1'b1;
                released_reg[pick_reg] <= 1'b0;
                next_age_reg           <= next_age_reg + AGE_W'(1);
            end
        end
    end

    // scan trackers and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                rel_found_reg <= 1'b0;
                old_found_reg <= 1'b0;
            end
            else if ((state_reg == S_EVAL) && (op_reg == OP_NOTE_ON))
            begin
                if (rel_upd)
                    rel_found_reg <= 1'b1;
                old_found_reg <= 1'b1;
            end
            if (hit_take)
                pend_valid_reg <= 1'b1;
            else if (flush_push)
                pend_valid_reg <= 1'b0;
            if (pend_push || flush_push || final_push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= s_op;
            note_reg <= s_note;
            vel_reg  <= scaled_sum[VEL_W-1:0];
            lim_reg  <= start_lim;
            idx_reg  <= '0;
        end
        else if ((state_reg == S_EVAL) && (state_next == S_READ))
        begin
            idx_reg <= idx_reg + VOICE_W'(1);
        end

        if ((state_reg == S_EVAL) && (op_reg == OP_NOTE_ON))
        begin
            if (rel_upd)
            begin
                rel_pick_reg <= idx_reg;
                rel_age_reg  <= rd_age;
            end
            if (old_upd)
            begin
                old_pick_reg <= idx_reg;
                old_age_reg  <= rd_age;
            end
            if (!cur_play)
            begin
                act_reg  <= ACT_START;
                pick_reg <= idx_reg;
            end
            else if (note_match)
            begin
                act_reg  <= ACT_RETRIG;
                pick_reg <= idx_reg;
            end
            else
            begin
                act_reg  <= ACT_RETRIG;
                pick_reg <= steal_pick;
            end
        end

        if (hit_take)
        begin
            pend_act_reg   <= (op_reg == OP_ALL_SOUND_OFF) ? ACT_KILL : ACT_RELEASE;
            pend_voice_reg <= idx_reg;
            pend_note_reg  <= rd_note;
        end

        if (final_push)
        begin
            out_act_reg   <= act_reg;
            out_voice_reg <= pick_reg;
            out_note_reg  <= note_reg;
            out_vel_reg   <= vel_reg;
            out_age_reg   <= next_age_reg;
            out_last_reg  <= 1'b1;
        end
        else if (pend_push || flush_push)
        begin
            out_act_reg   <= pend_act_reg;
            out_voice_reg <= pend_voice_reg;
            out_note_reg  <= pend_note_reg;
            out_vel_reg   <= '0;
            out_age_reg   <= '0;
            out_last_reg  <= flush_push;
        end
    end

    // voice memory: note and age per voice, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (final_push)
            voice_mem[pick_reg] <= {note_reg, next_age_reg};
        if (mem_rd)
            rd_data_reg <= voice_mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_age_reg, out_vel_reg, out_note_reg, out_voice_reg,
                       out_act_reg};

endmodule

@@ dv/poly_voice_allocator_unit_tb.sv @@
// Self-checking testbench for the polyphonic voice allocator: stream driver, monitor, predictor.
module poly_voice_allocator_unit_tb
    import pva_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT = 20;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] note;
        logic [6:0] vel;
        logic [6:0] pedal;
        logic [2:0] vid;
        logic       drain;
    } midi_msg_t;

    typedef struct packed {
        act_t        action;
        logic [2:0]  voice;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [31:0] age;
        logic        last;
    } voice_action_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [55:0]        m_tdata;
    logic               m_tlast;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [SENS_W-1:0]  cfg_data = '0;

    poly_voice_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the allocator state
    logic [CNT_W-1:0]  shadow_count = 4'd8;
    logic [SENS_W-1:0] shadow_sens = 5'd16;
    bit                voice_busy [VOICES];
    bit                voice_rel [VOICES];
    logic [6:0]        voice_pitch [VOICES];
    logic [31:0]       voice_stamp [VOICES];
    logic [31:0]       stamp_ctr = '0;
    bit                sustain = 1'b0;

    midi_msg_t         pending_msgs[$];
    voice_action_t     expected_actions[$];
    voice_action_t     burst[$];
    int                sounding[$];
    midi_msg_t         cur_msg;
    bit                calm = 1'b0;
    int                mismatches = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2ms;
        $display("FAIL poly_voice_allocator_unit");
        $finish;
    end

    function automatic void claim_voice(act_t a, int k, logic [6:0] nt, logic [6:0] vel);
        voice_action_t r;
        r.action = a;
        r.voice = 3'(k);
        r.note = nt;
        r.vel = vel;
        r.age = stamp_ctr;
        r.last = 1'b0;
        burst.push_back(r);
        voice_busy[k] = 1'b1;
        voice_rel[k] = 1'b0;
        voice_pitch[k] = nt;
        voice_stamp[k] = stamp_ctr;
        stamp_ctr = stamp_ctr + 32'd1;
    endfunction

    // release or kill one voice
    function automatic void drop_voice(act_t a, int k);
        voice_action_t r;
        r.action = a;
        r.voice = 3'(k);
        r.note = voice_pitch[k];
        r.vel = '0;
        r.age = '0;
        r.last = 1'b0;
        burst.push_back(r);
        if (a == ACT_KILL)
        begin
            voice_busy[k] = 1'b0;
            voice_rel[k] = 1'b0;
        end
        else
        begin
            voice_rel[k] = 1'b1;
        end
    endfunction

    function automatic void release_everything();
        for (int k = 0; k < VOICES; k++)
            if (voice_busy[k] && !voice_rel[k])
                drop_voice(ACT_RELEASE, k);
    endfunction

    function automatic void allocate_voices(midi_msg_t m);
        int cnt;
        int sens;
        int floor_v;
        int scaled;
        int pick;
        bit found;
        bit done;
        voice_action_t r;
        burst.delete();
        cnt = int'(shadow_count);
        sens = int'(shadow_sens);
        if (cnt < 1) cnt = 1;
        if (cnt > VOICES) cnt = VOICES;
        if (sens < 1) sens = 1;
        if (sens > 16) sens = 16;
        found = 1'b0;
        done = 1'b0;
        pick = 0;
        case (m.opcode)
            OP_NOTE_ON:
            begin
                if (m.note >= NOTE_LOW && m.note <= NOTE_HIGH)
                begin
                    floor_v = (16 - sens) * 8;
                    scaled = floor_v + int'(m.vel) * (128 - floor_v) / 128;
                    for (int k = 0; k < cnt && !done; k++)
                    begin
                        if (!voice_busy[k])
                        begin
                            claim_voice(ACT_START, k, m.note, 7'(scaled));
                            done = 1'b1;
                        end
                        else if (voice_pitch[k] == m.note)
                        begin
                            claim_voice(ACT_RETRIG, k, m.note, 7'(scaled));
                            done = 1'b1;
                        end
                        else if (voice_rel[k] && (!found || voice_stamp[k] < voice_stamp[pick]))
                        begin
                            found = 1'b1;
                            pick = k;
                        end
                    end
                    if (!done)
                    begin
                        // no released voice: steal the oldest
                        if (!found)
                            for (int k = 0; k < cnt; k++)
                                if (!found || voice_stamp[k] < voice_stamp[pick])
                                begin
                                    found = 1'b1;
                                    pick = k;
                                end
                        claim_voice(ACT_RETRIG, pick, m.note, 7'(scaled));
                    end
                end
            end
            OP_NOTE_OFF:
            begin
                if (!sustain)
                    for (int k = 0; k < cnt; k++)
                        if (voice_busy[k] && !voice_rel[k] && voice_pitch[k] == m.note)
                            drop_voice(ACT_RELEASE, k);
            end
            OP_PEDAL:
            begin
                if (m.pedal < PEDAL_HALF)
                begin
                    sustain = 1'b0;
                    release_everything();
                end
                else
                begin
                    sustain = 1'b1;
                end
            end
            OP_VOICE_DONE:
            begin
                voice_busy[m.vid] = 1'b0;
                voice_rel[m.vid] = 1'b0;
            end
            OP_ALL_NOTES_OFF:
                release_everything();
            OP_ALL_SOUND_OFF:
            begin
                for (int k = 0; k < VOICES; k++)
                    if (voice_busy[k])
                        drop_voice(ACT_KILL, k);
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < burst.size(); i++)
        begin
            r = burst[i];
            r.last = (i == burst.size() - 1);
            expected_actions.push_back(r);
        end
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                allocate_voices(cur_msg);
            if (!s_tvalid || s_tready)
            begin
                if (pending_msgs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                    && !(pending_msgs[0].drain && expected_actions.size() > 0))
                begin
                    cur_msg = pending_msgs.pop_front();
                    s_tdata <= {5'd0, cur_msg.vid, cur_msg.pedal, cur_msg.vel,
                                cur_msg.note, cur_msg.opcode};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        voice_action_t want;
        voice_action_t got;
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action = act_t'(m_tdata[1:0]);
            got.voice = m_tdata[4:2];
            got.note = m_tdata[11:5];
            got.vel = m_tdata[18:12];
            got.age = m_tdata[50:19];
            got.last = m_tlast;
            if (expected_actions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: act=%0d voice=%0d note=%0d vel=%0d age=%0d last=%0b",
                             got.action, got.voice, got.note, got.vel, got.age, got.last);
            end
            else
            begin
                want = expected_actions.pop_front();
                if (got.action !== want.action || got.voice !== want.voice
                    || got.note !== want.note || got.vel !== want.vel
                    || got.age !== want.age || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp act=%0d voice=%0d note=%0d vel=%0d age=%0d last=%0b",
                                 want.action, want.voice, want.note, want.vel, want.age,
                                 want.last);
                        $display("          got act=%0d voice=%0d note=%0d vel=%0d age=%0d last=%0b",
                                 got.action, got.voice, got.note, got.vel, got.age,
                                 got.last);
                    end
                end
            end
        end
    end

    function automatic midi_msg_t msg(logic [2:0] op, int nt, int vel, int ped, int vid,
                                      bit drain);
        midi_msg_t m;
        m.opcode = op;
        m.note = 7'(nt);
        m.vel = 7'(vel);
        m.pedal = 7'(ped);
        m.vid = 3'(vid);
        m.drain = drain;
        return m;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [SENS_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VOICE_COUNT)
            shadow_count = val[CNT_W-1:0];
        else
            shadow_sens = val;
    endtask

    task automatic wait_quiet();
        while (pending_msgs.size() > 0 || s_tvalid || expected_actions.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        int roll;
        int nt;
        int idx;
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                op = OP_NOTE_ON;
                case ($urandom_range(9))
                    0: nt = $urandom_range(127);
                    1, 2, 3, 4: nt = $urandom_range(67, 60);
                    default: nt = $urandom_range(NOTE_HIGH, NOTE_LOW);
                endcase
                sounding.push_back(nt);
                if (sounding.size() > 16)
                    void'(sounding.pop_front());
            end
            else if (roll < 72)
            begin
                op = OP_NOTE_OFF;
                if (sounding.size() > 0 && $urandom_range(9) < 8)
                begin
                    idx = $urandom_range(sounding.size() - 1);
                    nt = sounding[idx];
                    sounding.delete(idx);
                end
                else
                begin
                    nt = $urandom_range(127);
                end
            end
            else
            begin
                nt = $urandom_range(127);
                if (roll < 80) op = OP_PEDAL;
                else if (roll < 88) op = OP_VOICE_DONE;
                else if (roll < 92) op = OP_ALL_NOTES_OFF;
                else if (roll < 95) op = OP_ALL_SOUND_OFF;
                else op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
                if (op == OP_ALL_SOUND_OFF)
                    sounding.delete();
            end
            pending_msgs.push_back(msg(op, nt, $urandom_range(127), $urandom_range(127),
                                       $urandom_range(7), $urandom_range(24) == 0));
        end
    endtask

    initial
    begin
        int counts[7];
        int sens[7];
        counts = '{1, 4, 0, 8, 15, 2, 6};
        sens = '{1, 9, 0, 16, 31, 12, 24};
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed: fill all voices, retrigger, steal, hold pedal, bulk events
        pending_msgs.push_back(msg(OP_NOTE_ON, 24, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 107, 127, 127, 7, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 23, 100, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 108, 100, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 0, 127, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 127, 127, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 60, 64, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 60, 90, 0, 0, 1));
        for (int n = 61; n <= 65; n++)
            pending_msgs.push_back(msg(OP_NOTE_ON, n, n, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 70, 1, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_OFF, 107, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_OFF, 62, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_OFF, 127, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 71, 50, 0, 0, 0));
        pending_msgs.push_back(msg(OP_PEDAL, 0, 0, 127, 0, 0));
        pending_msgs.push_back(msg(OP_NOTE_OFF, 63, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_PEDAL, 0, 0, 63, 0, 0));
        pending_msgs.push_back(msg(OP_PEDAL, 0, 0, 64, 0, 0));
        pending_msgs.push_back(msg(OP_PEDAL, 0, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_VOICE_DONE, 0, 0, 0, 3, 0));
        pending_msgs.push_back(msg(OP_VOICE_DONE, 0, 0, 0, 7, 0));
        pending_msgs.push_back(msg(OP_NOTE_ON, 80, 127, 0, 0, 0));
        pending_msgs.push_back(msg(OP_ALL_NOTES_OFF, 0, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_ALL_SOUND_OFF, 0, 0, 0, 0, 0));
        pending_msgs.push_back(msg(OP_SPARE_6, 60, 60, 0, 0, 0));
        pending_msgs.push_back(msg(OP_SPARE_7, 60, 60, 0, 0, 0));
        wait_quiet();

        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_VOICE_COUNT, SENS_W'(counts[p]));
            write_reg(CFG_VEL_SENS, SENS_W'(sens[p]));
            calm = (p == 3);
            queue_random(24);
            wait_quiet();
        end

        if (mismatches == 0 && expected_actions.size() == 0)
            $display("PASS poly_voice_allocator_unit");
        else
            $display("FAIL poly_voice_allocator_unit");
        $finish;
    end

endmodule
